### src/centered_fir_edge_clamp_unit_assert.svh
// Assertion macros for the centred FIR unit, clocked on clock and disabled in reset.
`ifndef CENTERED_FIR_EDGE_CLAMP_UNIT_ASSERT_SVH
`define CENTERED_FIR_EDGE_CLAMP_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define CFEC_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cfec: same-cycle check failed");
`define CFEC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cfec: next-cycle check failed");
`else
`define CFEC_ASSERT_IMPL(label, ante, cons)
`define CFEC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### src/cfec_pkg.sv
// Package of constants and types shared by the centred FIR unit.
`timescale 1ns / 1ps
`default_nettype none
package cfec_pkg;

   localparam int MAX_TAPS      = 7;
   localparam int SAMPLE_BITS   = 16;
   localparam int COEF_BITS     = 16;
   localparam int COEF_FRAC     = 14;
   localparam int TAP_CNT_BITS  = $clog2(MAX_TAPS + 1);
   localparam int TAP_IDX_BITS  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int CSR_IDX_BITS  = $clog2(MAX_TAPS + 1);
   localparam int CSR_DATA_BITS = COEF_BITS;
   localparam int PROD_BITS     = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_BITS      = PROD_BITS + $clog2(MAX_TAPS + 1);
   localparam int SEEN_SAT      = MAX_TAPS;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_BITS-1:0] REG_TAP_COUNT = CSR_IDX_BITS'(0);
   localparam int                      REG_COEF_BASE = 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic clear;
      logic mul_en;
   } mac_ctrl_type;

endpackage
`default_nettype wire

### src/cfec_history.sv
// Sample history line with edge clamping and an indexed read port.
`timescale 1ns / 1ps
`default_nettype none
module cfec_history (
   input  wire                                    clock,
   input  wire                                    load,
   input  wire                                    fill,
   input  wire  signed [cfec_pkg::SAMPLE_BITS-1:0] sample,
   input  wire         [cfec_pkg::TAP_IDX_BITS-1:0] rd_idx,
   output logic signed [cfec_pkg::SAMPLE_BITS-1:0] rd_data
);
   import cfec_pkg::*;

   logic signed [SAMPLE_BITS-1:0] hist_ff [MAX_TAPS];
   logic signed [SAMPLE_BITS-1:0] hist_in [MAX_TAPS];

   // A new signal floods the whole line with its first sample, so older
   // taps read the start value without any extra selection.
   always_comb begin
      hist_in[0] = sample;
      for (int k = 1; k < MAX_TAPS; k++) begin
         hist_in[k] = fill ? sample : hist_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         hist_ff <= hist_in;
      end
   end

   assign rd_data = hist_ff[rd_idx];

endmodule
`default_nettype wire

### src/cfec_mac.sv
// Shared multiply-accumulate unit with Q2.14 rounding and saturation.
`timescale 1ns / 1ps
`default_nettype none
module cfec_mac (
   input  wire                                     clock,
   input  wire                                     reset,
   input  cfec_pkg::mac_ctrl_type                  ctrl,
   input  wire  signed [cfec_pkg::SAMPLE_BITS-1:0] sample,
   input  wire  signed [cfec_pkg::COEF_BITS-1:0]   coef,
   output logic signed [cfec_pkg::SAMPLE_BITS-1:0] result
);
   import cfec_pkg::*;

   localparam int RND_BITS = ACC_BITS + 1;
   localparam int Q_BITS   = RND_BITS - COEF_FRAC;

   localparam logic signed [Q_BITS-1:0] SAT_MAX = Q_BITS'((2 ** (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [Q_BITS-1:0] SAT_MIN = -SAT_MAX - Q_BITS'(1);
   localparam logic signed [RND_BITS-1:0] HALF  = RND_BITS'(2 ** (COEF_FRAC - 1));

   logic signed [PROD_BITS-1:0] prod_ff, prod_in;
   logic                        prod_vld_ff, prod_vld_in;
   logic signed [ACC_BITS-1:0]  acc_ff, acc_in;
   logic signed [RND_BITS-1:0]  rnd;
   logic signed [Q_BITS-1:0]    quot;

   assign prod_in     = sample * coef;
   assign prod_vld_in = ctrl.mul_en;

   always_comb begin
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_BITS'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= prod_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
   end

   // Round half up, then floor: an arithmetic shift does the floor.
   assign rnd  = RND_BITS'(acc_ff) + HALF;
   assign quot = Q_BITS'(rnd >>> COEF_FRAC);

   always_comb begin
      if (quot > SAT_MAX) begin
         result = SAT_MAX[SAMPLE_BITS-1:0];
      end else if (quot < SAT_MIN) begin
         result = SAT_MIN[SAMPLE_BITS-1:0];
      end else begin
         result = quot[SAMPLE_BITS-1:0];
      end
   end

endmodule
`default_nettype wire

### src/centered_fir_edge_clamp_unit.sv
// Top level of the centred FIR filter with edge clamping.
`timescale 1ns / 1ps
`default_nettype none
// This block filters a stream of signed samples with a centred FIR kernel of
// one to seven taps, held in Q2.14 coefficient registers with a tap count.
// Before a signal's start the history is taken as the first sample, and a
// result is produced only once the sample index reaches the centring shift,
// (taps-1)/2, so the first few beats of a signal may give no result. A beat
// flagged first_sample, the first beat after reset and the beat after one
// flagged last_sample each begin a new signal. One multiplier is shared over
// all taps: from its acceptance to the earliest acceptance of the next beat,
// an item passes through the idle state in which it is accepted, a multiply
// state for each tap, a drain state for the product register and a final
// state that rounds and saturates. The result waits in an output register;
// if the previous result is not yet taken, the unit holds in its final state
// until that register frees. The user must write configuration only while the
// unit is idle, not enforced by the block; it applies from the next beat.
module centered_fir_edge_clamp_unit (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     req_valid,
   output logic                                    req_ready,
   input  wire  signed [cfec_pkg::SAMPLE_BITS-1:0] req_sample,
   input  wire                                     req_first_sample,
   input  wire                                     req_last_sample,
   output logic                                    rsp_valid,
   input  wire                                     rsp_ready,
   output logic signed [cfec_pkg::SAMPLE_BITS-1:0] rsp_filtered,
   output logic                                    rsp_end_of_signal,
   input  wire                                     csr_we,
   input  wire         [cfec_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire         [cfec_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import cfec_pkg::*;

   // Configuration registers.
   logic        [TAP_CNT_BITS-1:0] tap_count_ff;
   logic signed [COEF_BITS-1:0]    coef_ff [MAX_TAPS];

   // Sequencer state.
   state_type                  state_ff, state_in;
   logic [TAP_IDX_BITS-1:0]    tap_idx_ff, tap_idx_in;
   logic [TAP_CNT_BITS-1:0]    seen_ff, seen_in;
   logic                       emit_ff, emit_in;
   logic                       last_ff, last_in;

   // Output register.
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_filtered_ff;
   logic                       rsp_end_ff;

   logic                       accept;
   logic                       fill;
   logic [TAP_CNT_BITS-1:0]    taps_eff;
   logic [TAP_CNT_BITS-1:0]    shift;
   logic [TAP_IDX_BITS-1:0]    tap_last;
   logic [TAP_CNT_BITS-1:0]    cur_idx;
   logic                       out_free;
   logic                       out_load;
   logic                       tap_step;
   mac_ctrl_type               mac_ctrl;
   logic signed [SAMPLE_BITS-1:0] hist_data;
   logic signed [SAMPLE_BITS-1:0] mac_result;

   // Configuration writes. Tap count zero acts as one tap, and a count
   // above the kernel length acts as the full kernel.
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= TAP_CNT_BITS'(1);
         for (int k = 0; k < MAX_TAPS; k++) begin
            coef_ff[k] <= (k == 0) ? COEF_BITS'(2 ** COEF_FRAC) : '0;
         end
      end else if (csr_we) begin
         if (csr_index == REG_TAP_COUNT) begin
            tap_count_ff <= csr_wdata[TAP_CNT_BITS-1:0];
         end
         for (int k = 0; k < MAX_TAPS; k++) begin
            if (csr_index == CSR_IDX_BITS'(k + REG_COEF_BASE)) begin
               coef_ff[k] <= csr_wdata[COEF_BITS-1:0];
            end
         end
      end
   end

   always_comb begin
      if (tap_count_ff == '0) begin
         taps_eff = TAP_CNT_BITS'(1);
      end else if (tap_count_ff > TAP_CNT_BITS'(MAX_TAPS)) begin
         taps_eff = TAP_CNT_BITS'(MAX_TAPS);
      end else begin
         taps_eff = tap_count_ff;
      end
   end

   assign shift    = (taps_eff - TAP_CNT_BITS'(1)) >> 1;
   assign tap_last = TAP_IDX_BITS'(taps_eff - TAP_CNT_BITS'(1));

   // A beat opens a new signal on its flag, or when nothing has been seen
   // since reset or since the previous signal's last beat.
   assign accept  = req_valid && req_ready;
   assign fill    = req_first_sample || (seen_ff == '0);
   assign cur_idx = fill ? '0 : seen_ff;

   always_comb begin
      seen_in = seen_ff;
      emit_in = emit_ff;
      last_in = last_ff;
      if (accept) begin
         emit_in = (cur_idx >= shift);
         last_in = req_last_sample;
         if (req_last_sample) begin
            seen_in = '0;
         end else if (cur_idx < TAP_CNT_BITS'(SEEN_SAT)) begin
            seen_in = cur_idx + TAP_CNT_BITS'(1);
         end else begin
            seen_in = cur_idx;
         end
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            if (tap_idx_ff == tap_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!emit_ff || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output logic of the sequencer.
   always_comb begin
      req_ready       = 1'b0;
      mac_ctrl.clear  = 1'b0;
      mac_ctrl.mul_en = 1'b0;
      tap_step        = 1'b0;
      out_load        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready      = 1'b1;
            mac_ctrl.clear = req_valid;
         end
         ST_MAC: begin
            mac_ctrl.mul_en = 1'b1;
            tap_step        = 1'b1;
         end
         ST_DRAIN: begin
         end
         ST_FINISH: begin
            out_load = emit_ff && out_free;
         end
         default: begin
         end
      endcase
   end

   // The counter returns to tap zero after the last tap, so it never points
   // past the kernel.
   always_comb begin
      if (accept) begin
         tap_idx_in = '0;
      end else if (tap_step) begin
         tap_idx_in = (tap_idx_ff == tap_last) ? '0 : tap_idx_ff + TAP_IDX_BITS'(1);
      end else begin
         tap_idx_in = tap_idx_ff;
      end
   end

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tap_idx_ff   <= '0;
         seen_ff      <= '0;
         emit_ff      <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tap_idx_ff   <= tap_idx_in;
         seen_ff      <= seen_in;
         emit_ff      <= emit_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_filtered_ff <= mac_result;
         rsp_end_ff      <= last_ff;
      end
   end

   cfec_history u_history (
      .clock   (clock),
      .load    (accept),
      .fill    (fill),
      .sample  (req_sample),
      .rd_idx  (tap_idx_ff),
      .rd_data (hist_data)
   );

   cfec_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mac_ctrl),
      .sample (hist_data),
      .coef   (coef_ff[tap_idx_ff]),
      .result (mac_result)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_filtered      = rsp_filtered_ff;
   assign rsp_end_of_signal = rsp_end_ff;

   // The tap counter never runs past the last tap in use.
   // An accepted beat always starts the multiply pass at tap zero.
   // A result appears only from the final step of an item that emits one.
`include "centered_fir_edge_clamp_unit_assert.svh"
   `CFEC_ASSERT_IMPL(tap_idx_in_range_a, state_ff == ST_MAC, tap_idx_ff <= tap_last)
   `CFEC_ASSERT_NEXT(accept_starts_mac_a, req_valid && req_ready,
                     state_ff == ST_MAC && tap_idx_ff == '0)
   `CFEC_ASSERT_IMPL(result_from_finish_a, $rose(rsp_valid_ff),
                     $past(state_ff == ST_FINISH && emit_ff))

endmodule
`default_nettype wire
